### rtl/core/hntrm_pkg.sv
`default_nettype none

package hntrm_pkg;

    // Descriptor layout: four 64-bit input words, of which the low
    // DESC_WORDS32 32-bit words take part in the distance.
    localparam int DESC_WORDS32 = 8;
    localparam int INDEX_BITS   = 12;
    localparam int LEVEL_BITS   = 3;

    localparam int DESC_BITS = 256;
    localparam int USED_BITS = DESC_WORDS32 * 32;
    localparam int DIST_W    = 9;
    localparam int LVL_W     = 4;
    localparam int CFG_W     = 9;

    localparam logic [DIST_W-1:0] NO_DIST     = 9'd256;
    localparam logic [LVL_W-1:0]  NO_LEVEL    = 4'hF;
    localparam logic [CFG_W-1:0]  RATIO_RESET = 9'd154;
    localparam logic [CFG_W-1:0]  MAXD_RESET  = 9'd100;

    typedef enum logic {
        REG_RATIO_Q8     = 1'b0,
        REG_MAX_DISTANCE = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_QUERY = 1'b0,
        KIND_CAND  = 1'b1
    } t_kind;

    // One request as it moves down the pipeline
    typedef struct packed {
        t_kind                  kind;
        logic                   observed;
        logic                   last;
        logic [LEVEL_BITS-1:0]  lvl;
        logic [INDEX_BITS-1:0]  idx;
        logic [DIST_W-1:0]      ham_dist;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0]      best_dist;
        logic [DIST_W-1:0]      second_dist;
        logic [LVL_W-1:0]       best_lvl;
        logic [LVL_W-1:0]       second_lvl;
        logic [INDEX_BITS-1:0]  best_idx;
    } t_track;

    localparam t_track TRACK_CLEAR = '{
        best_dist:   NO_DIST,
        second_dist: NO_DIST,
        best_lvl:    NO_LEVEL,
        second_lvl:  NO_LEVEL,
        best_idx:    '0
    };

endpackage

`default_nettype wire

### rtl/core/hntrm_dist.sv
`default_nettype none

module hntrm_dist import hntrm_pkg::*; (
    input  wire logic [DESC_BITS-1:0] i_query,
    input  wire logic [DESC_BITS-1:0] i_desc,
    output logic      [DIST_W-1:0]    o_dist
);

    logic [DESC_BITS-1:0] diff;
    logic [3:0] cnt_l0 [32];
    logic [4:0] cnt_l1 [16];
    logic [5:0] cnt_l2 [8];
    logic [6:0] cnt_l3 [4];
    logic [7:0] cnt_l4 [2];

    always_comb begin
        for (int b = 0; b < DESC_BITS; b++) begin
            diff[b] = (b < USED_BITS) ? (i_query[b] ^ i_desc[b]) : 1'b0;
        end
        // byte counts, then a balanced adder tree
        for (int i = 0; i < 32; i++) begin
            cnt_l0[i] = '0;
            for (int j = 0; j < 8; j++) begin
                cnt_l0[i] = cnt_l0[i] + 4'(diff[8*i+j]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            cnt_l1[i] = 5'(cnt_l0[2*i]) + 5'(cnt_l0[2*i+1]);
        end
        for (int i = 0; i < 8; i++) begin
            cnt_l2[i] = 6'(cnt_l1[2*i]) + 6'(cnt_l1[2*i+1]);
        end
        for (int i = 0; i < 4; i++) begin
            cnt_l3[i] = 7'(cnt_l2[2*i]) + 7'(cnt_l2[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            cnt_l4[i] = 8'(cnt_l3[2*i]) + 8'(cnt_l3[2*i+1]);
        end
        o_dist = 9'(cnt_l4[0]) + 9'(cnt_l4[1]);
    end

endmodule

`default_nettype wire

### rtl/core/hntrm_track.sv
`default_nettype none

module hntrm_track import hntrm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_go,
    input  wire t_item  i_item,
    output t_track      o_next
);

    t_track r_track;
    t_track n_track;

    always_comb begin
        n_track = r_track;
        if (i_go) begin
            if (i_item.kind == KIND_QUERY) begin
                n_track = TRACK_CLEAR;
            end else if (!i_item.observed) begin
                priority if (i_item.ham_dist < r_track.best_dist) begin
                    // demote the old best
                    n_track.second_dist = r_track.best_dist;
                    n_track.second_lvl  = r_track.best_lvl;
                    n_track.best_dist   = i_item.ham_dist;
                    n_track.best_lvl    = LVL_W'(i_item.lvl);
                    n_track.best_idx    = i_item.idx;
                end else if (i_item.ham_dist < r_track.second_dist) begin
                    n_track.second_dist = i_item.ham_dist;
                    n_track.second_lvl  = LVL_W'(i_item.lvl);
                end else begin
                    n_track = r_track;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= TRACK_CLEAR;
        end else begin
            r_track <= n_track;
        end
    end

    assign o_next = n_track;

endmodule

`default_nettype wire

### rtl/core/hamming_two_nearest_ratio_match_unit.sv
// Nearest / second-nearest Hamming matcher with a ratio test.
// Input channel (i_in_valid / o_in_ready) takes one request per cycle while o_in_ready is high: a
// query (kind 0) loads the 256-bit reference descriptor and clears the
// tracker; a candidate (kind 1) is compared by Hamming distance unless it is
// marked as already observed. A request with last set yields one verdict on
// the output channel (o_out_valid / i_out_ready); other requests yield none.
// Throughput: one request per cycle while o_in_ready is high. Pipeline: input
// register and popcount tree, tracker update, ratio multiply, output register.
// A last request passes through stages A, B and C, then the output register.
// When the receiver stalls, non-last requests keep flowing through the
// tracker; up to two verdicts wait in the pipeline, and input is held off
// only once a further last request cannot advance.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at the
// next edge: index 0 is ratio_q8, index 1 is max_distance.
// Reset (synchronous, active low) empties the pipeline, zeroes the query,
// clears the tracker and sets ratio_q8 to 154 and max_distance to 100.
`default_nettype none

module hamming_two_nearest_ratio_match_unit import hntrm_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,

    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_kind,
    input  wire logic [63:0]            i_desc_word0,
    input  wire logic [63:0]            i_desc_word1,
    input  wire logic [63:0]            i_desc_word2,
    input  wire logic [63:0]            i_desc_word3,
    input  wire logic [LEVEL_BITS-1:0]  i_scale_level,
    input  wire logic [INDEX_BITS-1:0]  i_candidate_index,
    input  wire logic                   i_already_observed,
    input  wire logic                   i_last,

    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_matched,
    output logic [INDEX_BITS-1:0]       o_match_index,
    output logic [DIST_W-1:0]           o_best_distance,
    output logic [DIST_W-1:0]           o_second_distance
);

    logic [CFG_W-1:0]     r_ratio_q8;
    logic [CFG_W-1:0]     r_max_dist;
    logic [DESC_BITS-1:0] r_query;

    logic                 r_a_valid;
    t_item                r_a;
    logic [DESC_BITS-1:0] r_a_desc;

    logic                 r_b_valid;
    t_item                r_b;

    logic                 r_c_valid;
    t_track               r_c;

    logic                 r_out_valid;
    logic                 r_matched;
    logic [INDEX_BITS-1:0] r_match_index;
    logic [DIST_W-1:0]    r_best;
    logic [DIST_W-1:0]    r_second;

    logic                 out_free;
    logic                 c_free;
    logic                 b_go;
    logic                 b_free;
    logic                 a_free;
    logic                 in_acc;
    logic [DIST_W-1:0]    a_dist;
    t_item                a_item;
    t_track               track_next;

    logic                 dist_ok;
    logic                 same_lvl;
    logic [17:0]          lhs;
    logic [17:0]          rhs;
    logic                 n_matched;

    // Handshake chain: a stage moves when the one after it can take it.
    // Only last requests occupy the verdict stages.
    assign out_free   = !r_out_valid || i_out_ready;
    assign c_free     = !r_c_valid || out_free;
    assign b_go       = r_b_valid && (!r_b.last || c_free);
    assign b_free     = !r_b_valid || b_go;
    assign a_free     = !r_a_valid || b_free;
    assign in_acc     = i_in_valid && a_free;
    assign o_in_ready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_q8 <= RATIO_RESET;
            r_max_dist <= MAXD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RATIO_Q8:     r_ratio_q8 <= i_cfg_wdata;
                REG_MAX_DISTANCE: r_max_dist <= i_cfg_wdata;
            endcase
        end
    end

    // Load the query at accept; candidates already in stage A were issued
    // before it and have finished with the old query by then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (in_acc && (t_kind'(i_kind) == KIND_QUERY)) begin
            r_query <= {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
        end
    end

    // Stage A: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a.kind     <= t_kind'(i_kind);
            r_a.observed <= i_already_observed;
            r_a.last     <= i_last;
            r_a.lvl      <= i_scale_level;
            r_a.idx      <= i_candidate_index;
            r_a.ham_dist <= '0;
            r_a_desc     <= {i_desc_word3, i_desc_word2, i_desc_word1, i_desc_word0};
        end
    end

    hntrm_dist u_dist (
        .i_query (r_query),
        .i_desc  (r_a_desc),
        .o_dist  (a_dist)
    );

    always_comb begin
        a_item          = r_a;
        a_item.ham_dist = a_dist;
    end

    // Stage B: distance register, feeds the tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_b <= a_item;
        end
    end

    hntrm_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (b_go),
        .i_item  (r_b),
        .o_next  (track_next)
    );

    // Stage C: tracker snapshot after a last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= b_go && r_b.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free && b_go && r_b.last) begin
            r_c <= track_next;
        end
    end

    // Verdict: distance limit, then ratio test when both levels agree
    always_comb begin
        dist_ok   = (r_c.best_dist != NO_DIST) && (r_c.best_dist <= r_max_dist);
        same_lvl  = (r_c.best_lvl == r_c.second_lvl);
        lhs       = {1'b0, r_c.best_dist, 8'b0};
        rhs       = 18'(r_ratio_q8) * 18'(r_c.second_dist);
        n_matched = dist_ok && !(same_lvl && (lhs > rhs));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_c_valid) begin
            r_matched     <= n_matched;
            r_match_index <= n_matched ? r_c.best_idx : '0;
            r_best        <= r_c.best_dist;
            r_second      <= r_c.second_dist;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_matched         = r_matched;
    assign o_match_index     = r_match_index;
    assign o_best_distance   = r_best;
    assign o_second_distance = r_second;

endmodule

`default_nettype wire

### sim/hamming_two_nearest_ratio_match_unit_tb.sv
`default_nettype none

module hamming_two_nearest_ratio_match_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hntrm_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int GAP_PERCENT    = 23;

    localparam logic [DESC_BITS-1:0] ALL_ONES  = '1;
    localparam logic [DESC_BITS-1:0] USED_MASK = {DESC_BITS{1'b1}} >> (DESC_BITS - USED_BITS);

    typedef struct {
        t_kind                  kind;
        logic [DESC_BITS-1:0]   desc;
        logic [LEVEL_BITS-1:0]  lvl;
        logic [INDEX_BITS-1:0]  idx;
        logic                   observed;
        logic                   last;
    } t_match_req;

    typedef struct {
        logic                   matched;
        logic [INDEX_BITS-1:0]  idx;
        logic [DIST_W-1:0]      best;
        logic [DIST_W-1:0]      second;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_reg_idx               i_cfg_idx = REG_RATIO_Q8;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_kind                  i_kind = KIND_QUERY;
    logic [63:0]            i_desc_word0 = '0;
    logic [63:0]            i_desc_word1 = '0;
    logic [63:0]            i_desc_word2 = '0;
    logic [63:0]            i_desc_word3 = '0;
    logic [LEVEL_BITS-1:0]  i_scale_level = '0;
    logic [INDEX_BITS-1:0]  i_candidate_index = '0;
    logic                   i_already_observed = 1'b0;
    logic                   i_last = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_matched;
    logic [INDEX_BITS-1:0]  o_match_index;
    logic [DIST_W-1:0]      o_best_distance;
    logic [DIST_W-1:0]      o_second_distance;

    // Predicted matcher state
    logic [DESC_BITS-1:0]   query_desc = '0;
    logic [DIST_W-1:0]      trk_best = NO_DIST;
    logic [DIST_W-1:0]      trk_second = NO_DIST;
    logic [LVL_W-1:0]       trk_best_lvl = NO_LEVEL;
    logic [LVL_W-1:0]       trk_second_lvl = NO_LEVEL;
    logic [INDEX_BITS-1:0]  trk_best_idx = '0;
    logic [CFG_W-1:0]       cfg_ratio = RATIO_RESET;
    logic [CFG_W-1:0]       cfg_max = MAXD_RESET;

    t_verdict               expected_verdicts[$];
    int unsigned            mismatches = 0;
    int unsigned            quiet_cycles = 0;
    bit                     steady = 1'b0;
    int unsigned            hold_epoch = 0;
    int unsigned            hold_seen = 0;
    int unsigned            hold_left = 0;

    hamming_two_nearest_ratio_match_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_desc_word0       (i_desc_word0),
        .i_desc_word1       (i_desc_word1),
        .i_desc_word2       (i_desc_word2),
        .i_desc_word3       (i_desc_word3),
        .i_scale_level      (i_scale_level),
        .i_candidate_index  (i_candidate_index),
        .i_already_observed (i_already_observed),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_matched          (o_matched),
        .o_match_index      (o_match_index),
        .o_best_distance    (o_best_distance),
        .o_second_distance  (o_second_distance)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    function automatic logic [DESC_BITS-1:0] random_desc();
        logic [DESC_BITS-1:0] d;
        for (int w = 0; w < DESC_BITS / 32; w++) begin
            d[w*32 +: 32] = $urandom;
        end
        return d;
    endfunction

    // Flip exactly n_flip distinct bits of the query
    function automatic logic [DESC_BITS-1:0] at_distance(logic [DESC_BITS-1:0] q, int n_flip);
        logic [DESC_BITS-1:0] flips;
        int n;
        int pos;
        flips = '0;
        n = 0;
        while (n < n_flip) begin
            pos = $urandom_range(DESC_BITS - 1);
            if (!flips[pos]) begin
                flips[pos] = 1'b1;
                n++;
            end
        end
        return q ^ flips;
    endfunction

    function automatic t_match_req query_req(logic [DESC_BITS-1:0] desc, logic last);
        t_match_req r;
        r.kind     = KIND_QUERY;
        r.desc     = desc;
        r.lvl      = LEVEL_BITS'($urandom);
        r.idx      = INDEX_BITS'($urandom);
        r.observed = 1'($urandom_range(1));
        r.last     = last;
        return r;
    endfunction

    function automatic t_match_req cand_req(logic [DESC_BITS-1:0] desc,
                                            logic [LEVEL_BITS-1:0] lvl,
                                            logic [INDEX_BITS-1:0] idx,
                                            logic observed, logic last);
        t_match_req r;
        r.kind     = KIND_CAND;
        r.desc     = desc;
        r.lvl      = lvl;
        r.idx      = idx;
        r.observed = observed;
        r.last     = last;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting(logic [CFG_W-1:0] typical);
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_W'(256);
            2: return typical;
            default: return CFG_W'($urandom_range(256));
        endcase
    endfunction

    // Advance the predicted tracker by one accepted request; queue a verdict on last
    task automatic track_request(input t_match_req r);
        logic [DIST_W-1:0] ham;
        int unsigned lhs;
        int unsigned rhs;
        logic ok;
        t_verdict v;
        if (r.kind == KIND_QUERY) begin
            query_desc     = r.desc;
            trk_best       = NO_DIST;
            trk_second     = NO_DIST;
            trk_best_lvl   = NO_LEVEL;
            trk_second_lvl = NO_LEVEL;
            trk_best_idx   = '0;
        end else if (!r.observed) begin
            ham = DIST_W'($countones((query_desc ^ r.desc) & USED_MASK));
            if (ham < trk_best) begin
                trk_second     = trk_best;
                trk_second_lvl = trk_best_lvl;
                trk_best       = ham;
                trk_best_lvl   = LVL_W'(r.lvl);
                trk_best_idx   = r.idx;
            end else if (ham < trk_second) begin
                trk_second     = ham;
                trk_second_lvl = LVL_W'(r.lvl);
            end
        end
        if (r.last) begin
            ok  = (trk_best < NO_DIST) && (trk_best <= cfg_max);
            lhs = 32'(trk_best) * 32'd256;
            rhs = 32'(cfg_ratio) * 32'(trk_second);
            if (ok && trk_best_lvl == trk_second_lvl && lhs > rhs) begin
                ok = 1'b0;
            end
            v.matched = ok;
            v.idx     = ok ? trk_best_idx : '0;
            v.best    = trk_best;
            v.second  = trk_second;
            expected_verdicts = {expected_verdicts, v};
        end
    endtask

    task automatic send_request(input t_match_req r);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_kind             <= r.kind;
        i_desc_word0       <= r.desc[63:0];
        i_desc_word1       <= r.desc[127:64];
        i_desc_word2       <= r.desc[191:128];
        i_desc_word3       <= r.desc[255:192];
        i_scale_level      <= r.lvl;
        i_candidate_index  <= r.idx;
        i_already_observed <= r.observed;
        i_last             <= r.last;
        do @(posedge i_clk); while (!o_in_ready);
        track_request(r);
    endtask

    // Drop valid, drain all verdicts, then let in-flight requests clear the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx which, input logic [CFG_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= which;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (which == REG_RATIO_Q8) begin
            cfg_ratio = value;
        end else begin
            cfg_max = value;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic test_empty_and_skipped();
        send_request(query_req('0, 1'b1));
        send_request(query_req(ALL_ONES, 1'b0));
        send_request(cand_req(ALL_ONES, '1, '1, 1'b1, 1'b1));
        // full distance is never recorded
        send_request(cand_req('0, '0, '0, 1'b0, 1'b1));
    endtask

    task automatic test_nearest_tracking();
        logic [DESC_BITS-1:0] q;
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(q, '1, '1, 1'b0, 1'b1));
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(at_distance(q, 30), 3'd1, 12'd10, 1'b0, 1'b0));
        send_request(cand_req(at_distance(q, 30), 3'd2, 12'd11, 1'b0, 1'b0));
        send_request(cand_req(at_distance(q, 40), 3'd1, 12'd12, 1'b0, 1'b0));
        send_request(cand_req(at_distance(q, 25), 3'd0, 12'd13, 1'b0, 1'b1));
    endtask

    task automatic test_ratio_rule();
        logic [DESC_BITS-1:0] q;
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(at_distance(q, 10), 3'd3, 12'd1, 1'b0, 1'b0));
        send_request(cand_req(at_distance(q, 12), 3'd3, 12'd2, 1'b0, 1'b1));
    endtask

    task automatic test_distance_limit();
        logic [DESC_BITS-1:0] q;
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(at_distance(q, 101), 3'd6, 12'd2048, 1'b0, 1'b1));
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(at_distance(q, 100), 3'd6, 12'd1365, 1'b0, 1'b1));
    endtask

    task automatic test_config_extremes();
        logic [DESC_BITS-1:0] q;
        write_reg(REG_RATIO_Q8, '0);
        write_reg(REG_MAX_DISTANCE, CFG_W'(256));
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(at_distance(q, 5), 3'd4, 12'd100, 1'b0, 1'b0));
        send_request(cand_req(at_distance(q, 50), 3'd4, 12'd101, 1'b0, 1'b1));
        write_reg(REG_RATIO_Q8, CFG_W'(256));
        write_reg(REG_MAX_DISTANCE, '0);
        q = random_desc();
        send_request(query_req(q, 1'b0));
        send_request(cand_req(q, 3'd5, 12'd7, 1'b0, 1'b0));
        send_request(cand_req(q, 3'd5, 12'd8, 1'b0, 1'b1));
    endtask

    // Mostly well-formed query/candidate runs, some noise and abandoned runs
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned n_cand;
        int unsigned reach;
        bit abandon;
        logic [DESC_BITS-1:0] q;
        logic [LEVEL_BITS-1:0] seq_lvl;
        t_match_req r;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                r = cand_req(random_desc(), LEVEL_BITS'($urandom), INDEX_BITS'($urandom),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
                r.kind = t_kind'($urandom_range(1));
                send_request(r);
                sent++;
            end else begin
                q       = random_desc();
                seq_lvl = LEVEL_BITS'($urandom);
                n_cand  = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
                abandon = ($urandom_range(19) == 0);
                case ($urandom_range(2))
                    0: reach = 20;
                    1: reach = 130;
                    default: reach = DESC_BITS;
                endcase
                send_request(query_req(q, n_cand == 0));
                sent++;
                for (int k = 1; k <= n_cand; k++) begin
                    r = cand_req(($urandom_range(3) == 0) ? random_desc()
                                                          : at_distance(q, $urandom_range(reach)),
                                 $urandom_range(1) ? seq_lvl : LEVEL_BITS'($urandom),
                                 INDEX_BITS'($urandom), $urandom_range(99) < 20,
                                 k == n_cand && !abandon);
                    send_request(r);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_RATIO_Q8, pick_setting(RATIO_RESET));
            write_reg(REG_MAX_DISTANCE, pick_setting(MAXD_RESET));
            run_random_phase(200);
        end
    endtask

    task automatic test_back_to_back();
        write_reg(REG_RATIO_Q8, RATIO_RESET);
        write_reg(REG_MAX_DISTANCE, CFG_W'($urandom_range(130, 60)));
        steady = 1'b1;
        run_random_phase(150);
        steady = 1'b0;
    endtask

    // Receiver holds off while short runs keep coming, so the input backs up
    task automatic test_output_stall();
        logic [DESC_BITS-1:0] q;
        hold_epoch++;
        for (int n = 0; n < 60; n++) begin
            q = random_desc();
            send_request(query_req(q, 1'b0));
            send_request(cand_req(at_distance(q, $urandom_range(60)), LEVEL_BITS'($urandom),
                                  INDEX_BITS'($urandom), 1'b0, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_epoch) begin
            hold_seen   <= hold_epoch;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !take_gap();
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict with none pending, index %0d", o_match_index));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_matched !== want.matched)
                    report_mismatch($sformatf("matched got %0b expected %0b",
                                              o_matched, want.matched));
                if (o_match_index !== want.idx)
                    report_mismatch($sformatf("match_index got %0d expected %0d",
                                              o_match_index, want.idx));
                if (o_best_distance !== want.best)
                    report_mismatch($sformatf("best_distance got %0d expected %0d",
                                              o_best_distance, want.best));
                if (o_second_distance !== want.second)
                    report_mismatch($sformatf("second_distance got %0d expected %0d",
                                              o_second_distance, want.second));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_skipped();
        test_nearest_tracking();
        test_ratio_rule();
        test_distance_limit();
        test_config_extremes();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();
        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### hamming_two_nearest_ratio_match_unit.f
rtl/core/hntrm_pkg.sv
rtl/core/hntrm_dist.sv
rtl/core/hntrm_track.sv
rtl/core/hamming_two_nearest_ratio_match_unit.sv
sim/hamming_two_nearest_ratio_match_unit_tb.sv
